// ----- src/mfp_pkg.sv -----
package mfp_pkg;

    localparam int EXTRA_ENTRIES = 8;

    typedef enum logic {
        KIND_LINK = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    localparam logic [7:0]  START_BYTE = 8'hFD;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;

    localparam logic [8:0] POS_IDLE   = 9'd0;
    localparam logic [8:0] POS_LENGTH = 9'd1;
    localparam logic [8:0] POS_SYSTEM = 9'd5;
    localparam logic [8:0] POS_COMP   = 9'd6;
    localparam logic [8:0] POS_ID_LO  = 9'd7;
    localparam logic [8:0] POS_ID_MID = 9'd8;
    localparam logic [8:0] POS_ID_HI  = 9'd9;
    localparam logic [8:0] HDR_BYTES  = 9'd10;

    localparam logic [23:0] EXTRA_IDS [EXTRA_ENTRIES] = '{
        24'd0, 24'd22, 24'd23, 24'd76, 24'd77, 24'd283, 24'd284, 24'd285
    };
    localparam logic [7:0] EXTRA_VALS [EXTRA_ENTRIES] = '{
        8'd50, 8'd220, 8'd168, 8'd152, 8'd143, 8'd74, 8'd99, 8'd137
    };

    // CRC-16/MCRF4XX, one byte
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
               ^ {12'h000, t[7:4]};
    endfunction

    function automatic logic [7:0] extra_for(input logic [23:0] id);
        logic [7:0] v;
        v = 8'h00;
        for (int i = 0; i < EXTRA_ENTRIES; i++) begin
            if (EXTRA_IDS[i] == id) begin
                v = v | EXTRA_VALS[i];
            end
        end
        return v;
    endfunction

endpackage

// ----- src/mfp_ram.sv -----
module mfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/mavlink2_frame_parser_top.sv -----
// MAVLink v2 frame receiver. Each item is either a link byte (kind 0) or a
// read of the last delivered payload (kind 1); each item yields one result.
// A new item is taken every cycle while results are taken. The item register
// and the payload memory read register load at the edge that accepts an item;
// the output register loads from them when the output advances. A stalled
// output holds the input off after one item. The payload memory holds two
// banks: frames are received into one while the other serves reads, and a
// frame with a good CRC swaps them, so no copy is needed. Reads at or beyond
// the delivered length return 0.
module mavlink2_frame_parser_top #(
    parameter int PAYLOAD_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_ok,
    output logic [23:0] message_id,
    output logic [7:0]  source_system,
    output logic [7:0]  source_component,
    output logic [7:0]  delivered_length,
    output logic [7:0]  read_data
);
    import mfp_pkg::*;

    localparam int AW = $clog2(PAYLOAD_DEPTH);
    localparam int RAM_DEPTH = 2 * PAYLOAD_DEPTH;

    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [23:0] id_reg, id_next;
    logic [7:0]  sys_reg, sys_next;
    logic [7:0]  comp_reg, comp_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic        bank_reg, bank_next;
    logic [23:0] hdr_id_reg, hdr_id_next;
    logic [7:0]  hdr_sys_reg, hdr_sys_next;
    logic [7:0]  hdr_comp_reg, hdr_comp_next;
    logic [7:0]  hdr_len_reg, hdr_len_next;

    logic        p1_valid_reg;
    logic        p1_ok_reg, p1_ok_next;
    logic        p1_rd_reg, p1_rd_next;

    logic        out_valid_reg;
    logic        out_ok_reg;
    logic [23:0] out_id_reg;
    logic [7:0]  out_sys_reg;
    logic [7:0]  out_comp_reg;
    logic [7:0]  out_len_reg;
    logic [7:0]  out_data_reg;

    logic        p1_adv;
    logic        accept;
    logic        we;
    logic        re;
    logic [AW:0] waddr;
    logic [AW:0] raddr;
    logic [7:0]  ram_q;
    logic [8:0]  pay_end;
    logic [8:0]  pay_off;
    logic [15:0] crc_upd;
    logic [15:0] crc_expect;

    assign p1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !p1_valid_reg || p1_adv;
    assign accept   = in_valid && in_ready;

    assign pay_end    = HDR_BYTES + {1'b0, len_reg};
    assign pay_off    = pos_reg - HDR_BYTES;
    assign crc_upd    = crc_step(crc_reg, data_byte);
    assign crc_expect = crc_step(crc_reg, extra_for(id_reg));

    assign waddr = {!bank_reg, pay_off[AW-1:0]};
    assign raddr = {bank_reg, read_index[AW-1:0]};
    assign re    = accept && (kind_t'(kind) == KIND_READ);

    always_comb
    begin
        pos_next      = pos_reg;
        len_next      = len_reg;
        crc_next      = crc_reg;
        id_next       = id_reg;
        sys_next      = sys_reg;
        comp_next     = comp_reg;
        crc_lo_next   = crc_lo_reg;
        bank_next     = bank_reg;
        hdr_id_next   = hdr_id_reg;
        hdr_sys_next  = hdr_sys_reg;
        hdr_comp_next = hdr_comp_reg;
        hdr_len_next  = hdr_len_reg;
        p1_ok_next    = 1'b0;
        p1_rd_next    = 1'b0;
        we            = 1'b0;
        if (accept)
        begin
            case (kind_t'(kind))
                KIND_READ:
                begin
                    p1_rd_next = read_index < hdr_len_reg;
                end
                KIND_LINK:
                begin
                    if (pos_reg == POS_IDLE)
                    begin
                        if (data_byte == START_BYTE)
                        begin
                            crc_next = CRC_SEED;
                            pos_next = POS_LENGTH;
                        end
                    end
                    else if (pos_reg < HDR_BYTES)
                    begin
                        case (pos_reg)
                            POS_LENGTH: len_next = data_byte;
                            POS_SYSTEM: sys_next = data_byte;
                            POS_COMP:   comp_next = data_byte;
                            POS_ID_LO:  id_next[7:0] = data_byte;
                            POS_ID_MID: id_next[15:8] = data_byte;
                            POS_ID_HI:  id_next[23:16] = data_byte;
                            default:    ;
                        endcase
                        crc_next = crc_upd;
                        pos_next = pos_reg + 9'd1;
                    end
                    else if (pos_reg < pay_end)
                    begin
                        we       = 1'b1;
                        crc_next = crc_upd;
                        pos_next = pos_reg + 9'd1;
                    end
                    else if (pos_reg == pay_end)
                    begin
                        crc_lo_next = data_byte;
                        pos_next    = pos_reg + 9'd1;
                    end
                    else
                    begin
                        if (crc_expect == {data_byte, crc_lo_reg})
                        begin
                            p1_ok_next    = 1'b1;
                            hdr_id_next   = id_reg;
                            hdr_sys_next  = sys_reg;
                            hdr_comp_next = comp_reg;
                            hdr_len_next  = len_reg;
                            bank_next     = !bank_reg;
                        end
                        pos_next = POS_IDLE;
                        crc_next = CRC_SEED;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_IDLE;
            len_reg       <= '0;
            crc_reg       <= CRC_SEED;
            id_reg        <= '0;
            sys_reg       <= '0;
            comp_reg      <= '0;
            crc_lo_reg    <= '0;
            bank_reg      <= 1'b0;
            hdr_id_reg    <= '0;
            hdr_sys_reg   <= '0;
            hdr_comp_reg  <= '0;
            hdr_len_reg   <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            crc_reg      <= crc_next;
            id_reg       <= id_next;
            sys_reg      <= sys_next;
            comp_reg     <= comp_next;
            crc_lo_reg   <= crc_lo_next;
            bank_reg     <= bank_next;
            hdr_id_reg   <= hdr_id_next;
            hdr_sys_reg  <= hdr_sys_next;
            hdr_comp_reg <= hdr_comp_next;
            hdr_len_reg  <= hdr_len_next;
            if (in_ready)
            begin
                p1_valid_reg <= in_valid;
            end
            if (p1_adv)
            begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    // item flags and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_ok_reg <= p1_ok_next;
            p1_rd_reg <= p1_rd_next;
        end
        if (p1_adv && p1_valid_reg)
        begin
            out_ok_reg   <= p1_ok_reg;
            out_id_reg   <= hdr_id_reg;
            out_sys_reg  <= hdr_sys_reg;
            out_comp_reg <= hdr_comp_reg;
            out_len_reg  <= hdr_len_reg;
            out_data_reg <= p1_rd_reg ? ram_q : 8'h00;
        end
    end

    mfp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (data_byte),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign out_valid        = out_valid_reg;
    assign frame_ok         = out_ok_reg;
    assign message_id       = out_id_reg;
    assign source_system    = out_sys_reg;
    assign source_component = out_comp_reg;
    assign delivered_length = out_len_reg;
    assign read_data        = out_data_reg;

endmodule
